@@ src/strip_hit_clusterer_assert.svh @@
// assertion macros of the strip hit clusterer checker
`ifndef STRIP_HIT_CLUSTERER_ASSERT_SVH
`define STRIP_HIT_CLUSTERER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SHC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shc assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define SHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shc assertion failed");

`endif

@@ src/shc_pkg.sv @@
// types, constants and helpers of the strip hit clusterer
`default_nettype none

package shc_pkg;

    localparam int STRIP_W  = 7;
    localparam int CHARGE_W = 12;
    localparam int TIME_W   = 9;
    localparam int CNUM_W   = 6;
    localparam int KEY_W    = STRIP_W + 1;

    // action codes
    localparam logic ACT_STORE  = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // one stored hit
    typedef struct packed {
        logic                axis;
        logic [STRIP_W-1:0]  strip;
        logic [CHARGE_W-1:0] charge;
        logic [TIME_W-1:0]   hit_time;
    } t_hit;

    localparam int HIT_W = $bits(t_hit);

    // one result word
    typedef struct packed {
        t_hit              hit;
        logic [CNUM_W-1:0] cluster_number;
        logic              cluster_end;
        logic              event_end;
        logic              overflow;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_PLACE,
        S_FIRST,
        S_NEXT,
        S_LAST
    } t_state;

    // sort key: axis then strip
    function automatic logic [KEY_W-1:0] hit_key(input t_hit h);
        return {h.axis, h.strip};
    endfunction

    // true when nxt does not continue the cluster of cur
    function automatic logic cluster_break(input t_hit cur, input t_hit nxt);
        logic [STRIP_W:0] limit;
        limit = {1'b0, cur.strip} + {{STRIP_W{1'b0}}, 1'b1};
        return (nxt.axis != cur.axis) || ({1'b0, nxt.strip} > limit);
    endfunction

endpackage

`default_nettype wire

@@ src/shc_channels.sv @@
// valid/ready channel interfaces for hit words and result words
`default_nettype none

interface shc_in_if;
    import shc_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic                axis;
    logic [STRIP_W-1:0]  strip;
    logic [CHARGE_W-1:0] charge;
    logic [TIME_W-1:0]   hit_time;

    modport source (output valid, action, axis, strip, charge, hit_time, input ready);
    modport sink   (input valid, action, axis, strip, charge, hit_time, output ready);
endinterface

interface shc_out_if;
    import shc_pkg::*;

    logic                valid;
    logic                ready;
    logic                out_axis;
    logic [STRIP_W-1:0]  out_strip;
    logic [CHARGE_W-1:0] out_charge;
    logic [TIME_W-1:0]   out_time;
    logic [CNUM_W-1:0]   cluster_number;
    logic                cluster_end;
    logic                event_end;
    logic                overflow;

    modport source (output valid, out_axis, out_strip, out_charge, out_time,
                    cluster_number, cluster_end, event_end, overflow, input ready);
    modport sink   (input valid, out_axis, out_strip, out_charge, out_time,
                    cluster_number, cluster_end, event_end, overflow, output ready);
endinterface

`default_nettype wire

@@ src/shc_ram.sv @@
// generic simple dual-port ram, one write port, registered read port
`default_nettype none

module shc_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/strip_hit_clusterer.sv @@
// strip hit clusterer: a hit store kept sorted by axis and strip, read out in clusters
// store word: taken in idle if the store is empty or the hit is ignored, else shifted in via S_INSERT
// finish word: taken in idle if empty, else read out through S_FIRST, S_NEXT and S_LAST, one result per
// cycle while the output is not stalled; shift and readout share the ram read port, ready is low meanwhile
// reset clears the hit count, the drop flag, the state and the output valid
// store contents are undefined after reset; no clearing pass, only entries below the count are read
`default_nettype none

module strip_hit_clusterer #(
    parameter int MAX_HITS   = 64,
    parameter int NUM_STRIPS = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    shc_in_if.sink     i_hit,
    shc_out_if.source  o_res
);
    import shc_pkg::*;

    localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CW = $clog2(MAX_HITS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_HITS);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_dropped, n_dropped;
    t_hit              r_new, n_new;
    logic [AW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_idx, n_idx;
    t_hit              r_cur, n_cur;
    logic [CNUM_W-1:0] r_cnum, n_cnum;
    logic              r_ov;
    t_res              r_res;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_hit              ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    t_hit              ram_rdata;

    logic              in_ready;
    logic              in_range;
    logic              out_free;
    logic              out_load;
    t_res              out_data;
    logic              brk;
    t_hit              in_hit;
    logic [CW-1:0]     cnt_m1;

    // hit store
    shc_ram #(
        .WIDTH (HIT_W),
        .DEPTH (MAX_HITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // input decode
    assign in_range = int'({1'b0, i_hit.strip}) < NUM_STRIPS;
    assign in_hit   = '{axis: i_hit.axis, strip: i_hit.strip,
                        charge: i_hit.charge, hit_time: i_hit.hit_time};
    assign cnt_m1   = r_count - CW'(1);
    assign out_free = !r_ov || o_res.ready;
    assign brk      = cluster_break(r_cur, ram_rdata);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_new  <= n_new;
        r_j    <= n_j;
        r_idx  <= n_idx;
        r_cur  <= n_cur;
        r_cnum <= n_cnum;
    end

    // next state, ram control and result forming
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_new     = r_new;
        n_j       = r_j;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_cnum    = r_cnum;
        ram_we    = 1'b0;
        ram_waddr = r_j;
        ram_wdata = r_new;
        ram_re    = 1'b0;
        ram_raddr = '0;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        out_data  = '{hit: r_cur, cluster_number: r_cnum, cluster_end: brk,
                      event_end: 1'b0, overflow: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_hit.valid) begin
                    if (i_hit.action == ACT_FINISH) begin
                        if (r_count == '0) begin
                            n_dropped = 1'b0;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = CW'(1);
                            n_state   = S_FIRST;
                        end
                    end else if (in_range) begin
                        if (r_count == FULL) begin
                            n_dropped = 1'b1;
                        end else if (r_count == '0) begin
                            n_new     = in_hit;
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = in_hit;
                            n_count   = r_count + CW'(1);
                        end else begin
                            // walk down from the top, shifting larger keys up
                            n_new     = in_hit;
                            ram_re    = 1'b1;
                            ram_raddr = AW'(cnt_m1);
                            n_j       = AW'(r_count);
                            n_state   = S_INSERT;
                        end
                    end
                end
            end
            S_INSERT: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                if (hit_key(ram_rdata) > hit_key(r_new)) begin
                    ram_wdata = ram_rdata;
                    n_j       = r_j - AW'(1);
                    if (r_j == AW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_j - AW'(2);
                    end
                end else begin
                    ram_wdata = r_new;
                    n_count   = r_count + CW'(1);
                    n_state   = S_IDLE;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_state   = S_IDLE;
            end
            S_FIRST: begin
                n_cur  = ram_rdata;
                n_cnum = '0;
                if (r_count == CW'(1)) begin
                    n_state = S_LAST;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx);
                    n_idx     = r_idx + CW'(1);
                    n_state   = S_NEXT;
                end
            end
            S_NEXT: begin
                // ram data is the successor of the held hit
                if (out_free) begin
                    out_load = 1'b1;
                    n_cur    = ram_rdata;
                    if (ram_rdata.axis != r_cur.axis) begin
                        n_cnum = '0;
                    end else if (brk) begin
                        n_cnum = r_cnum + CNUM_W'(1);
                    end
                    if (r_idx == r_count) begin
                        n_state = S_LAST;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(r_idx);
                        n_idx     = r_idx + CW'(1);
                    end
                end
            end
            S_LAST: begin
                out_data.cluster_end = 1'b1;
                out_data.event_end   = 1'b1;
                out_data.overflow    = r_dropped;
                if (out_free) begin
                    out_load  = 1'b1;
                    n_count   = '0;
                    n_dropped = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res <= out_data;
        end
    end

    // ports
    assign i_hit.ready          = in_ready;
    assign o_res.valid          = r_ov;
    assign o_res.out_axis       = r_res.hit.axis;
    assign o_res.out_strip      = r_res.hit.strip;
    assign o_res.out_charge     = r_res.hit.charge;
    assign o_res.out_time       = r_res.hit.hit_time;
    assign o_res.cluster_number = r_res.cluster_number;
    assign o_res.cluster_end    = r_res.cluster_end;
    assign o_res.event_end      = r_res.event_end;
    assign o_res.overflow       = r_res.overflow;

endmodule

`default_nettype wire

@@ src/shc_checker.sv @@
// port-level checker of the strip hit clusterer and its bind
`default_nettype none

`include "strip_hit_clusterer_assert.svh"

module shc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_res_valid,
    input wire logic                         i_res_ready,
    input wire logic [shc_pkg::STRIP_W-1:0]  i_res_strip,
    input wire logic [shc_pkg::CHARGE_W-1:0] i_res_charge,
    input wire logic [shc_pkg::CNUM_W-1:0]   i_res_cnum,
    input wire logic                         i_res_cluster_end,
    input wire logic                         i_res_event_end,
    input wire logic                         i_res_overflow
);
    import shc_pkg::*;

    // a stalled word keeps its valid
    `SHC_ASSERT_NEXT(a_valid_hold, i_res_valid && !i_res_ready, i_res_valid)

    // a stalled word keeps its payload
    `SHC_ASSERT_NEXT(a_word_hold, i_res_valid && !i_res_ready, $stable(i_res_strip) && $stable(i_res_charge) && $stable(i_res_cnum) && $stable(i_res_event_end))

    // drop flag is only reported on the last word of an event
    `SHC_ASSERT_IMPL(a_ovf_last, i_res_valid && i_res_overflow, i_res_event_end)

    // the last word of an event also closes its cluster
    `SHC_ASSERT_IMPL(a_end_closes, i_res_valid && i_res_event_end, i_res_cluster_end)

endmodule

bind strip_hit_clusterer shc_checker u_shc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_strip       (o_res.out_strip),
    .i_res_charge      (o_res.out_charge),
    .i_res_cnum        (o_res.cluster_number),
    .i_res_cluster_end (o_res.cluster_end),
    .i_res_event_end   (o_res.event_end),
    .i_res_overflow    (o_res.overflow)
);

`default_nettype wire

@@ tb/sv/shc_result_checker.sv @@
// result checker of the strip hit clusterer: predicts readouts and compares words
module shc_result_checker #(
    parameter int MAX_HITS   = 64,
    parameter int NUM_STRIPS = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    shc_in_if         i_hit,
    shc_out_if        i_res,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results,
    output int        o_overflow_events
);
    import shc_pkg::*;

    // shadow of the event store
    t_hit stored_hits [MAX_HITS];
    int   stored_count = 0;
    bit   hits_dropped = 1'b0;

    // readout words still owed by the block, oldest first
    t_res owed_readout [$];

    int mismatches      = 0;
    int results_seen    = 0;
    int overflow_events = 0;

    function automatic string res_text(input t_res r);
        return $sformatf("axis=%0d strip=%0d charge=%0d time=%0d cluster=%0d cend=%0b eend=%0b ovf=%0b",
                         r.hit.axis, r.hit.strip, r.hit.charge, r.hit.hit_time,
                         r.cluster_number, r.cluster_end, r.event_end, r.overflow);
    endfunction

    // sort the stored hits by axis then strip, keeping arrival order, and label clusters
    task automatic predict_readout();
        t_hit sorted [MAX_HITS];
        t_hit w;
        t_res r;
        int   i;
        int   k;
        int   cnum;
        logic cend;
        for (i = 0; i < stored_count; i++) begin
            w = stored_hits[i];
            k = i;
            while (k > 0 && {sorted[k-1].axis, sorted[k-1].strip} > {w.axis, w.strip}) begin
                sorted[k] = sorted[k-1];
                k--;
            end
            sorted[k] = w;
        end
        cnum = 0;
        for (k = 0; k < stored_count; k++) begin
            if (k > 0) begin
                if (sorted[k-1].axis != sorted[k].axis)
                    cnum = 0;
                else if (int'(sorted[k].strip) > int'(sorted[k-1].strip) + 1)
                    cnum++;
            end
            if (k == stored_count - 1)
                cend = 1'b1;
            else
                cend = (sorted[k+1].axis != sorted[k].axis)
                    || (int'(sorted[k+1].strip) > int'(sorted[k].strip) + 1);
            r.hit            = sorted[k];
            r.cluster_number = cnum[CNUM_W-1:0];
            r.cluster_end    = cend;
            r.event_end      = (k == stored_count - 1);
            r.overflow       = (k == stored_count - 1) && hits_dropped;
            owed_readout     = {owed_readout, r};
        end
        if (hits_dropped && stored_count > 0)
            overflow_events++;
        stored_count = 0;
        hits_dropped = 1'b0;
    endtask

    // accepted input word: store a hit or start a readout
    task automatic take_word();
        t_hit h;
        h.axis     = i_hit.axis;
        h.strip    = i_hit.strip;
        h.charge   = i_hit.charge;
        h.hit_time = i_hit.hit_time;
        if (i_hit.action == ACT_FINISH) begin
            predict_readout();
        end else if (int'(h.strip) < NUM_STRIPS) begin
            if (stored_count < MAX_HITS) begin
                stored_hits[stored_count] = h;
                stored_count++;
            end else begin
                hits_dropped = 1'b1;
            end
        end
    endtask

    // accepted result word: compare with the oldest owed word
    task automatic check_result();
        t_res got;
        t_res want;
        got.hit.axis       = i_res.out_axis;
        got.hit.strip      = i_res.out_strip;
        got.hit.charge     = i_res.out_charge;
        got.hit.hit_time   = i_res.out_time;
        got.cluster_number = i_res.cluster_number;
        got.cluster_end    = i_res.cluster_end;
        got.event_end      = i_res.event_end;
        got.overflow       = i_res.overflow;
        results_seen++;
        if (owed_readout.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with nothing owed: %s", results_seen, res_text(got));
        end else begin
            want = owed_readout.pop_front();
            if (got.hit.axis !== want.hit.axis || got.hit.strip !== want.hit.strip
                || got.hit.charge !== want.hit.charge
                || got.hit.hit_time !== want.hit.hit_time
                || got.cluster_number !== want.cluster_number
                || got.cluster_end !== want.cluster_end
                || got.event_end !== want.event_end || got.overflow !== want.overflow) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch, expected %s", results_seen, res_text(want));
                    $display("result %0d mismatch, actual   %s", results_seen, res_text(got));
                end
            end
        end
    endtask

    // watch both channels at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_count = 0;
            hits_dropped = 1'b0;
            owed_readout.delete();
        end else begin
            if (i_res.valid && i_res.ready)
                check_result();
            if (i_hit.valid && i_hit.ready)
                take_word();
        end
        o_fail_count      <= mismatches;
        o_pending         <= owed_readout.size();
        o_results         <= results_seen;
        o_overflow_events <= overflow_events;
    end

endmodule

@@ tb/sv/tb_strip_hit_clusterer.sv @@
// testbench top of the strip hit clusterer: clock, reset, hit stimulus and verdict
module tb_strip_hit_clusterer;
    import shc_pkg::*;

    localparam int MAX_HITS     = 64;
    localparam int NUM_STRIPS   = 128;
    localparam int RANDOM_WORDS = 370;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    shc_in_if  hit_ch ();
    shc_out_if res_ch ();

    int fail_count;
    int pending;
    int results_checked;
    int overflow_events;

    int cycle_count  = 0;
    int words_sent   = 0;
    int events_run   = 0;
    bit idle_on      = 1'b1;
    bit stall_on     = 1'b1;
    bit hold_wanted  = 1'b0;
    bit hold_done    = 1'b0;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    strip_hit_clusterer #(
        .MAX_HITS   (MAX_HITS),
        .NUM_STRIPS (NUM_STRIPS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hit   (hit_ch),
        .o_res   (res_ch)
    );

    shc_result_checker #(
        .MAX_HITS   (MAX_HITS),
        .NUM_STRIPS (NUM_STRIPS)
    ) u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_hit             (hit_ch),
        .i_res             (res_ch),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results         (results_checked),
        .o_overflow_events (overflow_events)
    );

    function automatic t_hit rand_hit(input logic axis, input logic [STRIP_W-1:0] strip);
        t_hit h;
        h.axis     = axis;
        h.strip    = strip;
        h.charge   = CHARGE_W'($urandom_range(0, 4095));
        h.hit_time = TIME_W'($urandom_range(0, 511));
        return h;
    endfunction

    function automatic t_hit make_hit(input logic axis, input int strip, input int charge,
                                      input int hit_time);
        t_hit h;
        h.axis     = axis;
        h.strip    = STRIP_W'(strip);
        h.charge   = CHARGE_W'(charge);
        h.hit_time = TIME_W'(hit_time);
        return h;
    endfunction

    // offer one word, with a random idle burst ahead of it, and wait for the accept
    task automatic offer_word(input logic act, input t_hit h);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            hit_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        hit_ch.valid    <= 1'b1;
        hit_ch.action   <= act;
        hit_ch.axis     <= h.axis;
        hit_ch.strip    <= h.strip;
        hit_ch.charge   <= h.charge;
        hit_ch.hit_time <= h.hit_time;
        @(posedge i_clk);
        while (!hit_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // one event: hits spread around a base strip per axis (or anywhere when noisy), then finish
    task automatic run_event(input int n_hits, input bit noisy);
        t_hit h;
        int   base [2];
        int   span;
        int   i;
        base[0] = $urandom_range(0, 127);
        base[1] = $urandom_range(0, 127);
        span    = $urandom_range(1, 12);
        for (i = 0; i < n_hits; i++) begin
            h = rand_hit(1'($urandom_range(0, 1)), '0);
            if (noisy)
                h.strip = STRIP_W'($urandom_range(0, 127));
            else
                h.strip = STRIP_W'(base[h.axis] + $urandom_range(0, span));
            offer_word(ACT_STORE, h);
        end
        offer_word(ACT_FINISH, rand_hit(1'($urandom_range(0, 1)),
                                        STRIP_W'($urandom_range(0, 127))));
        events_run++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_wanted && !hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (stall_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int directed_words;
        int ev;
        int r;
        int n;
        int i;
        i_rst_n         <= 1'b0;
        hit_ch.valid    <= 1'b0;
        hit_ch.action   <= ACT_STORE;
        hit_ch.axis     <= 1'b0;
        hit_ch.strip    <= '0;
        hit_ch.charge   <= '0;
        hit_ch.hit_time <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // finish on an empty store, other fields set
        offer_word(ACT_FINISH, make_hit(1'b1, 127, 4095, 511));
        // field extremes, a duplicate strip, a strip gap, both axes out of order
        offer_word(ACT_STORE, make_hit(1'b0, 127, 4095, 511));
        offer_word(ACT_STORE, make_hit(1'b0, 0, 0, 0));
        offer_word(ACT_STORE, make_hit(1'b1, 1, 100, 10));
        offer_word(ACT_STORE, make_hit(1'b1, 3, 200, 20));
        offer_word(ACT_STORE, make_hit(1'b1, 1, 300, 30));
        offer_word(ACT_STORE, make_hit(1'b1, 0, 400, 40));
        offer_word(ACT_STORE, make_hit(1'b0, 126, 2730, 341));
        offer_word(ACT_STORE, make_hit(1'b1, 127, 1365, 170));
        offer_word(ACT_STORE, make_hit(1'b1, 5, 4095, 0));
        offer_word(ACT_FINISH, make_hit(1'b1, 127, 4095, 511));
        // store is empty again after a finish
        offer_word(ACT_FINISH, make_hit(1'b0, 0, 0, 0));
        // single hit event
        offer_word(ACT_STORE, make_hit(1'b1, 64, 2048, 256));
        offer_word(ACT_FINISH, make_hit(1'b0, 0, 0, 0));
        events_run += 4;
        directed_words = words_sent;

        ev = 0;
        while (words_sent - directed_words < RANDOM_WORDS) begin
            if (words_sent - directed_words > RANDOM_WORDS * 4 / 5) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            if (ev == 0) begin
                // full store: 64 separated strips in descending order, then dropped hits
                for (i = 0; i < MAX_HITS; i++)
                    offer_word(ACT_STORE, rand_hit(1'b0, STRIP_W'(126 - 2 * i)));
                for (i = 0; i < 3; i++)
                    offer_word(ACT_STORE, rand_hit(1'($urandom_range(0, 1)),
                                                   STRIP_W'($urandom_range(0, 127))));
                offer_word(ACT_FINISH, rand_hit(1'b0, '0));
                events_run++;
            end else if (ev == 2) begin
                // long output hold-off while the next events keep coming
                hold_wanted <= 1'b1;
                run_event(6, 1'b0);
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    n = $urandom_range(40, 70);
                else if (r == 1)
                    n = 0;
                else
                    n = $urandom_range(1, 16);
                run_event(n, $urandom_range(0, 3) == 0);
            end
            ev++;
        end
        hit_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d input words over %0d events, %0d result words checked",
                 words_sent, events_run, results_checked);
        $display("%0d events overflowed the hit store; one %0d-cycle output hold-off",
                 overflow_events, LONG_HOLD);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
